// ===== rtl/core/rcd_pkg.sv =====
package rcd_pkg;

    // APB register map, one 32-bit word per register
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_REF_RED    = 3'd0,
        REG_REF_GREEN  = 3'd1,
        REG_REF_BLUE   = 3'd2,
        REG_THRESH_EN  = 3'd3,
        REG_DIST_LIMIT = 3'd4
    } rcd_reg_t;

    localparam int unsigned REF_W   = 8;
    localparam int unsigned LIMIT_W = 9;
    localparam int unsigned LIM2_W  = 2 * LIMIT_W;
    localparam int unsigned OUT_W   = 17;

    localparam logic [OUT_W-1:0] PASS_VALUE = OUT_W'(255);
    localparam logic [OUT_W-1:0] FAIL_VALUE = '0;

    // side information that rides alongside each beat through the pipe
    typedef struct packed {
        logic mode;   // 1: threshold mode
        logic pass;   // squared distance below limit squared
    } rcd_tag_t;

endpackage

// ===== rtl/core/rcd_front.sv =====
module rcd_front #(
    parameter int unsigned PIXEL_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        vld_in,
    output logic                        rdy_out,
    input  logic [PIXEL_BITS-1:0]       red,
    input  logic [PIXEL_BITS-1:0]       green,
    input  logic [PIXEL_BITS-1:0]       blue,
    input  logic [PIXEL_BITS-1:0]       ref_red,
    input  logic [PIXEL_BITS-1:0]       ref_green,
    input  logic [PIXEL_BITS-1:0]       ref_blue,
    input  logic                        thresh_en,
    input  logic [rcd_pkg::LIM2_W-1:0]  lim2,
    output logic                        vld_out,
    input  logic                        rdy_in,
    output logic [2*PIXEL_BITS+1:0]     d2_out,
    output rcd_pkg::rcd_tag_t           tag_out
);
    import rcd_pkg::*;

    localparam int unsigned SQ_W = 2 * PIXEL_BITS;
    localparam int unsigned D2_W = SQ_W + 2;
    localparam int unsigned CMP_W = (D2_W > LIM2_W) ? D2_W : LIM2_W;

    logic                  vld_a_reg;
    logic                  mode_a_reg;
    logic [SQ_W-1:0]       sq_r_reg, sq_g_reg, sq_b_reg;
    logic [SQ_W-1:0]       sq_r_next, sq_g_next, sq_b_next;
    logic [PIXEL_BITS-1:0] dr, dg, db;
    logic [SQ_W-1:0]       dr_w, dg_w, db_w;
    logic                  rdy_a;

    logic                  vld_b_reg;
    logic [D2_W-1:0]       d2_reg, d2_next;
    rcd_tag_t              tag_reg, tag_next;

    // stage A: absolute differences and squares
    assign dr = (ref_red   >= red)   ? ref_red   - red   : red   - ref_red;
    assign dg = (ref_green >= green) ? ref_green - green : green - ref_green;
    assign db = (ref_blue  >= blue)  ? ref_blue  - blue  : blue  - ref_blue;
    assign dr_w = SQ_W'(dr);
    assign dg_w = SQ_W'(dg);
    assign db_w = SQ_W'(db);
    assign sq_r_next = dr_w * dr_w;
    assign sq_g_next = dg_w * dg_w;
    assign sq_b_next = db_w * db_w;

    assign rdy_out = !vld_a_reg || rdy_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
        end
        else if (rdy_out)
        begin
            vld_a_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_out)
        begin
            sq_r_reg   <= sq_r_next;
            sq_g_reg   <= sq_g_next;
            sq_b_reg   <= sq_b_next;
            mode_a_reg <= thresh_en;
        end
    end

    // stage B: sum and limit compare
    assign d2_next = D2_W'(sq_r_reg) + D2_W'(sq_g_reg) + D2_W'(sq_b_reg);
    assign tag_next.mode = mode_a_reg;
    assign tag_next.pass = CMP_W'(d2_next) < CMP_W'(lim2);

    assign rdy_a = !vld_b_reg || rdy_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_b_reg <= 1'b0;
        end
        else if (rdy_a)
        begin
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a)
        begin
            d2_reg  <= d2_next;
            tag_reg <= tag_next;
        end
    end

    assign vld_out = vld_b_reg;
    assign d2_out  = d2_reg;
    assign tag_out = tag_reg;

endmodule

// ===== rtl/core/rcd_sqrt_cell.sv =====
module rcd_sqrt_cell #(
    parameter int unsigned ROOT_BITS = 17
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     vld_in,
    output logic                     rdy_out,
    input  logic [ROOT_BITS:0]       rem_in,
    input  logic [ROOT_BITS-1:0]     root_in,
    input  logic [2*ROOT_BITS-1:0]   rad_in,
    input  rcd_pkg::rcd_tag_t        tag_in,
    output logic                     vld_out,
    input  logic                     rdy_in,
    output logic [ROOT_BITS:0]       rem_out,
    output logic [ROOT_BITS-1:0]     root_out,
    output logic [2*ROOT_BITS-1:0]   rad_out,
    output rcd_pkg::rcd_tag_t        tag_out
);
    import rcd_pkg::*;

    localparam int unsigned RADW = 2 * ROOT_BITS;

    logic                 vld_reg;
    logic [ROOT_BITS:0]   rem_reg, rem_next;
    logic [ROOT_BITS-1:0] root_reg, root_next;
    logic [RADW-1:0]      rad_reg, rad_next;
    rcd_tag_t             tag_reg;

    logic [ROOT_BITS+1:0] rem_sh;
    logic [ROOT_BITS+1:0] trial;
    logic [ROOT_BITS+1:0] diff;
    logic                 ge;

    // one restoring root digit: bring down two radicand bits, try root*4+1
    // remainder stays below 2^ROOT_BITS before the shift
    assign rem_sh = {rem_in[ROOT_BITS-1:0], rad_in[RADW-1:RADW-2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    assign rem_next  = ge ? diff[ROOT_BITS:0] : rem_sh[ROOT_BITS:0];
    assign root_next = {root_in[ROOT_BITS-2:0], ge};
    assign rad_next  = rad_in << 2;

    assign rdy_out = !vld_reg || rdy_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (rdy_out)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_out)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= rad_next;
            tag_reg  <= tag_in;
        end
    end

    assign vld_out  = vld_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign rad_out  = rad_reg;
    assign tag_out  = tag_reg;

endmodule

// ===== rtl/core/rgb_color_distance_threshold.sv =====
// Channel | Signals                                   | Beat
// --------+-------------------------------------------+--------------------------
// config  | psel penable pwrite paddr pwdata prdata   | write on access phase
// pixel   | in_valid in_ready red green blue          | one pixel
// result  | out_valid out_ready out_value             | one value per pixel
//
// One pixel per clock while out_ready stays high: the squares and the sum are
// registered in rcd_front, then one root digit per cell in the chain.
// Each stage holds while its successor is full and held, so bubbles close up behind a
// stalled result and the input keeps taking beats until the chain is full.
// Reset clears the valid bits and the config registers; no clearing pass.
module rgb_color_distance_threshold #(
    parameter int unsigned PIXEL_BITS = 8,
    parameter int unsigned FRAC_BITS  = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rcd_pkg::ADDR_W-1:0]   paddr,
    input  logic [rcd_pkg::DATA_W-1:0]   pwdata,
    output logic [rcd_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [PIXEL_BITS-1:0]        red,
    input  logic [PIXEL_BITS-1:0]        green,
    input  logic [PIXEL_BITS-1:0]        blue,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [rcd_pkg::OUT_W-1:0]    out_value
);
    import rcd_pkg::*;

    localparam int unsigned D2_W      = 2 * PIXEL_BITS + 2;
    localparam int unsigned ROOT_BITS = PIXEL_BITS + 1 + FRAC_BITS;
    localparam int unsigned RADW      = 2 * ROOT_BITS;

    logic [REF_W-1:0]   ref_red_reg, ref_green_reg, ref_blue_reg;
    logic               thresh_en_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [LIM2_W-1:0]  lim2_reg, lim2_next;
    logic [LIMIT_W-1:0] wr_limit;
    logic               wr_en;
    rcd_reg_t           reg_idx;

    // ---------------------------------------------------------------- config
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = rcd_reg_t'(paddr[ADDR_W-1:2]);
    assign wr_limit = pwdata[LIMIT_W-1:0];
    assign lim2_next = LIM2_W'(wr_limit) * LIM2_W'(wr_limit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_red_reg   <= '0;
            ref_green_reg <= '0;
            ref_blue_reg  <= '0;
            thresh_en_reg <= 1'b0;
            limit_reg     <= '0;
            lim2_reg      <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_REF_RED:    ref_red_reg   <= pwdata[REF_W-1:0];
                REG_REF_GREEN:  ref_green_reg <= pwdata[REF_W-1:0];
                REG_REF_BLUE:   ref_blue_reg  <= pwdata[REF_W-1:0];
                REG_THRESH_EN:  thresh_en_reg <= pwdata[0];
                REG_DIST_LIMIT:
                begin
                    limit_reg <= wr_limit;
                    lim2_reg  <= lim2_next;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_REF_RED:    prdata = DATA_W'(ref_red_reg);
            REG_REF_GREEN:  prdata = DATA_W'(ref_green_reg);
            REG_REF_BLUE:   prdata = DATA_W'(ref_blue_reg);
            REG_THRESH_EN:  prdata = DATA_W'(thresh_en_reg);
            REG_DIST_LIMIT: prdata = DATA_W'(limit_reg);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------ squares and sum
    logic              front_vld;
    logic [D2_W-1:0]   front_d2;
    rcd_tag_t          front_tag;

    logic [ROOT_BITS:0]                  cell_vld;
    logic [ROOT_BITS:0]                  cell_rdy;
    logic [ROOT_BITS:0][ROOT_BITS:0]     cell_rem;
    logic [ROOT_BITS:0][ROOT_BITS-1:0]   cell_root;
    logic [ROOT_BITS:0][RADW-1:0]        cell_rad;
    rcd_tag_t [ROOT_BITS:0]              cell_tag;

    rcd_front #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .vld_in    (in_valid),
        .rdy_out   (in_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .ref_red   (PIXEL_BITS'(ref_red_reg)),
        .ref_green (PIXEL_BITS'(ref_green_reg)),
        .ref_blue  (PIXEL_BITS'(ref_blue_reg)),
        .thresh_en (thresh_en_reg),
        .lim2      (lim2_reg),
        .vld_out   (front_vld),
        .rdy_in    (cell_rdy[0]),
        .d2_out    (front_d2),
        .tag_out   (front_tag)
    );

    // ------------------------------------------------------- root cell chain
    assign cell_vld[0]  = front_vld;
    assign cell_rem[0]  = '0;
    assign cell_root[0] = '0;
    assign cell_rad[0]  = RADW'(front_d2) << (2 * FRAC_BITS);
    assign cell_tag[0]  = front_tag;
    assign cell_rdy[ROOT_BITS] = out_ready;

    for (genvar k = 0; k < ROOT_BITS; k++)
    begin : g_cell
        rcd_sqrt_cell #(
            .ROOT_BITS (ROOT_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .vld_in   (cell_vld[k]),
            .rdy_out  (cell_rdy[k]),
            .rem_in   (cell_rem[k]),
            .root_in  (cell_root[k]),
            .rad_in   (cell_rad[k]),
            .tag_in   (cell_tag[k]),
            .vld_out  (cell_vld[k+1]),
            .rdy_in   (cell_rdy[k+1]),
            .rem_out  (cell_rem[k+1]),
            .root_out (cell_root[k+1]),
            .rad_out  (cell_rad[k+1]),
            .tag_out  (cell_tag[k+1])
        );
    end

    // the last cell's registers are the result register
    assign out_valid = cell_vld[ROOT_BITS];
    assign out_value = cell_tag[ROOT_BITS].mode
                     ? (cell_tag[ROOT_BITS].pass ? PASS_VALUE : FAIL_VALUE)
                     : OUT_W'(cell_root[ROOT_BITS]);

endmodule

// ===== rtl/core/rcd_checker.sv =====
module rcd_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [rcd_pkg::OUT_W-1:0] out_value
);
    import rcd_pkg::*;

    // a result beat held back by the sink must not move or vanish
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value))
        else $error("result beat changed while stalled");

    // a free-flowing sink lets every stage advance, so the input is open
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked while result side is draining");

    // an empty result stage always leaves room somewhere up the chain
    a_empty_tail: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty result stage");

    // while a beat drains with nothing stalled, the input is open
    a_drain_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> in_ready)
        else $error("input blocked while a result beat leaves");

endmodule

bind rgb_color_distance_threshold rcd_checker u_rcd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value)
);

// ===== dv/rgb_color_distance_checker.sv =====
module rgb_color_distance_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [rcd_pkg::ADDR_W-1:0]   paddr,
    input  logic [rcd_pkg::DATA_W-1:0]   pwdata,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [rcd_pkg::REF_W-1:0]    red,
    input  logic [rcd_pkg::REF_W-1:0]    green,
    input  logic [rcd_pkg::REF_W-1:0]    blue,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [rcd_pkg::OUT_W-1:0]    out_value,
    output int unsigned                  mismatch_count,
    output int unsigned                  pixels_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    import rcd_pkg::*;

    localparam int unsigned FRAC_BITS = 8;

    logic [REF_W-1:0]   ref_r;
    logic [REF_W-1:0]   ref_g;
    logic [REF_W-1:0]   ref_b;
    logic               thresh_on;
    logic [LIMIT_W-1:0] dist_limit;

    logic [OUT_W-1:0]   expected_out_values[$];

    function automatic logic [OUT_W-1:0] predict_out_value(
        input logic [REF_W-1:0] r,
        input logic [REF_W-1:0] g,
        input logic [REF_W-1:0] b
    );
        logic [REF_W-1:0] dr;
        logic [REF_W-1:0] dg;
        logic [REF_W-1:0] db;
        logic [63:0]      dist_sq;
        logic [63:0]      scaled;
        logic [63:0]      root;
        logic [63:0]      trial;
        dr = (r >= ref_r) ? r - ref_r : ref_r - r;
        dg = (g >= ref_g) ? g - ref_g : ref_g - g;
        db = (b >= ref_b) ? b - ref_b : ref_b - b;
        dist_sq = 64'(dr) * dr + 64'(dg) * dg + 64'(db) * db;
        if (thresh_on)
            return (dist_sq < 64'(dist_limit) * dist_limit) ? PASS_VALUE : FAIL_VALUE;
        // truncated root, one bit at a time from the top
        scaled = dist_sq << (2 * FRAC_BITS);
        root = '0;
        for (int i = 20; i >= 0; i--)
        begin
            trial = root | (64'd1 << i);
            if (trial * trial <= scaled)
                root = trial;
        end
        return OUT_W'(root);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [OUT_W-1:0] want;
        if (!rst_n)
        begin
            ref_r = '0;
            ref_g = '0;
            ref_b = '0;
            thresh_on = 1'b0;
            dist_limit = '0;
            expected_out_values.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_REF_RED:    ref_r = pwdata[REF_W-1:0];
                    REG_REF_GREEN:  ref_g = pwdata[REF_W-1:0];
                    REG_REF_BLUE:   ref_b = pwdata[REF_W-1:0];
                    REG_THRESH_EN:  thresh_on = pwdata[0];
                    REG_DIST_LIMIT: dist_limit = pwdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_out_values.size() == 0)
                begin
                    $error("out_value beat with no pixel outstanding: actual %0d", out_value);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_out_values.pop_front();
                    if (out_value !== want)
                    begin
                        $error("out_value mismatch: expected %0d, actual %0d", want, out_value);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_out_values.push_back(predict_out_value(red, green, blue));
        end
        pixels_in_flight = expected_out_values.size();
    end

endmodule

// ===== dv/tb_rgb_color_distance_threshold.sv =====
module tb_rgb_color_distance_threshold;
    timeunit 1ns;
    timeprecision 1ps;

    import rcd_pkg::*;

    localparam int unsigned PIX_W       = 8;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_WAIT  = 40;
    localparam int unsigned UNMAPPED_LO = int'(REG_DIST_LIMIT) + 1;
    localparam int unsigned UNMAPPED_HI = (1 << REG_IDX_W) - 1;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [PIX_W-1:0]  red = '0;
    logic [PIX_W-1:0]  green = '0;
    logic [PIX_W-1:0]  blue = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [OUT_W-1:0]  out_value;

    int unsigned       mismatch_count;
    int unsigned       pixels_in_flight;
    int unsigned       cycle_count = 0;

    bit                bursts_on = 1'b0;
    int unsigned       burst_left = 0;
    int unsigned       stall_mode = 0;
    logic [15:0]       ready_pattern = '1;
    int unsigned       pattern_pos = 0;

    rgb_color_distance_threshold dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_value (out_value)
    );

    rgb_color_distance_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_value        (out_value),
        .mismatch_count   (mismatch_count),
        .pixels_in_flight (pixels_in_flight)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side back-pressure: a 16-bit pattern played out from its top bit, reloaded on each wrap
    always @(negedge clk)
    begin
        if (pattern_pos == 0)
        begin
            case (stall_mode)
                0:       ready_pattern = '1;
                1:       ready_pattern = 16'($urandom());
                default: ready_pattern = 16'($urandom() & $urandom() & $urandom());
            endcase
            pattern_pos = 16;
        end
        pattern_pos--;
        out_ready <= ready_pattern[pattern_pos];
    end

    function automatic logic [DATA_W-1:0] with_junk(
        input logic [DATA_W-1:0] value,
        input int unsigned       width
    );
        // upper bits beyond the register width should be dropped by the block
        if ($urandom_range(0, 1) != 0)
            return value | (DATA_W'($urandom()) << width);
        return value;
    endfunction

    function automatic logic [PIX_W-1:0] pick_component(
        input logic [PIX_W-1:0] centre,
        input int unsigned      kind,
        input int               spread
    );
        int v;
        if (kind < 4)
            return PIX_W'($urandom_range(0, 255));
        if (kind < 8)
        begin
            v = int'(centre) + int'($urandom_range(0, 2 * spread)) - spread;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            return PIX_W'(v);
        end
        if (kind == 8)
            return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
        return centre;
    endfunction

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic program_colour(
        input logic [REF_W-1:0]   r,
        input logic [REF_W-1:0]   g,
        input logic [REF_W-1:0]   b,
        input logic               en,
        input logic [LIMIT_W-1:0] lim
    );
        write_reg(REG_REF_RED, with_junk(DATA_W'(r), REF_W));
        write_reg(REG_REF_GREEN, with_junk(DATA_W'(g), REF_W));
        write_reg(REG_REF_BLUE, with_junk(DATA_W'(b), REF_W));
        write_reg(REG_THRESH_EN, with_junk(DATA_W'(en), 1));
        write_reg(REG_DIST_LIMIT, with_junk(DATA_W'(lim), LIMIT_W));
        // unmapped slot last, so any aliasing onto a real register shows up
        write_reg(REG_IDX_W'($urandom_range(UNMAPPED_LO, UNMAPPED_HI)), $urandom());
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = bursts_on ? $urandom_range(1, 8) : 0;
            if (gap != 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        red <= r;
        green <= g;
        blue <= b;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pixels_in_flight != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [REF_W-1:0]   cr;
        logic [REF_W-1:0]   cg;
        logic [REF_W-1:0]   cb;
        logic [LIMIT_W-1:0] lim;
        int unsigned        kind;
        int                 spread;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // distance from black, including the far corner
        program_colour(8'd0, 8'd0, 8'd0, 1'b0, 9'd0);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'hAA, 8'h55, 8'hAA);
        send_pixel(8'h55, 8'hAA, 8'h55);
        wait_idle();

        program_colour(8'd255, 8'd255, 8'd255, 1'b0, 9'd0);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd127, 8'd1);
        wait_idle();

        // zero limit: nothing passes, not even the reference itself
        program_colour(8'd10, 8'd20, 8'd30, 1'b1, 9'd0);
        send_pixel(8'd10, 8'd20, 8'd30);
        send_pixel(8'd0, 8'd0, 8'd0);
        wait_idle();

        // strict compare at the boundary: d2 of 25 against limit 5
        program_colour(8'd0, 8'd0, 8'd0, 1'b1, 9'd5);
        send_pixel(8'd3, 8'd4, 8'd0);
        send_pixel(8'd3, 8'd3, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd4);
        send_pixel(8'd0, 8'd0, 8'd5);
        wait_idle();

        program_colour(8'd0, 8'd0, 8'd0, 1'b1, 9'd443);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        wait_idle();

        program_colour(8'd0, 8'd0, 8'd0, 1'b1, 9'd441);
        send_pixel(8'd255, 8'd255, 8'd255);
        wait_idle();

        for (int p = 0; p < 10; p++)
        begin
            case (p)
                0: {cr, cg, cb} = {8'd0, 8'd0, 8'd0};
                1: {cr, cg, cb} = {8'd255, 8'd255, 8'd255};
                2: {cr, cg, cb} = {8'd0, 8'd255, 8'd0};
                default: {cr, cg, cb} = 24'($urandom());
            endcase
            case (p)
                1:       lim = 9'd0;
                3:       lim = 9'd443;
                5:       lim = 9'd511;
                7:       lim = 9'($urandom_range(1, 40));
                default: lim = 9'($urandom_range(0, 511));
            endcase
            bursts_on = (p % 4 != 0);
            stall_mode = p % 3;
            program_colour(cr, cg, cb, 1'(p % 2), lim);
            repeat (90)
            begin
                kind = $urandom_range(0, 9);
                spread = $urandom_range(1, 48);
                send_pixel(pick_component(cr, kind, spread),
                           pick_component(cg, kind, spread),
                           pick_component(cb, kind, spread));
            end
            wait_idle();
        end

        repeat (DRAIN_WAIT) @(negedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rcd_pkg.sv
rtl/core/rcd_front.sv
rtl/core/rcd_sqrt_cell.sv
rtl/core/rgb_color_distance_threshold.sv
rtl/core/rcd_checker.sv
dv/rgb_color_distance_checker.sv
dv/tb_rgb_color_distance_threshold.sv
